FILE: rtl/core/bffm_pkg.sv
// Shared constants, types and helpers of the border flood fill marker.
`default_nettype none

package bffm_pkg;

  // Store geometry.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int CNT_W      = $clog2(CELLS + 1);

  // Fixed field widths.
  localparam int CHAR_W     = 8;
  localparam int FIELD_W    = 6;
  localparam int MARK_W     = 13;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;

  // Characters.
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRITE_WIDTH  = 2'd0,
    CFG_SPRITE_HEIGHT = 2'd1,
    CFG_SKIP_BOTTOM   = 2'd2
  } cfg_idx_t;

  // One access to the cell store.
  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } cell_req_t;

  // Cell store address of a column and row: row in the upper bits.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [FIELD_W-1:0] col,
                                                 input logic [FIELD_W-1:0] row);
    return {ROW_W'(row), COL_W'(col)};
  endfunction

  // Configured size, saturated to the store size.
  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v, input int maxv);
    return (int'(v) > maxv) ? DIM_W'(maxv) : DIM_W'(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bffm_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module bffm_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bffm_fill.sv
// Border flood fill sequencer with its pending-cell stack.
`default_nettype none

module bffm_fill
  import bffm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIM_W-1:0]  width,
  input  wire logic [DIM_W-1:0]  height,
  input  wire logic              skip_bottom,
  input  wire logic [CHAR_W-1:0] cell_rdata,
  output cell_req_t              cell_req,
  output logic                   done,
  output logic [CNT_W-1:0]       count
);

  typedef enum logic [4:0] {
    F_IDLE     = 5'b00001,
    F_PRB_RD   = 5'b00010,
    F_PRB_CHK  = 5'b00100,
    F_POP      = 5'b01000,
    F_POP_WAIT = 5'b10000
  } fill_state_t;

  fill_state_t       state_r, state_nxt;
  logic              seed_ph_r, seed_ph_nxt;
  logic [DIM_W-1:0]  seed_i_r, seed_i_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic [DIM_W-1:0]  cur_c_r, cur_c_nxt;
  logic [DIM_W-1:0]  cur_r_r, cur_r_nxt;
  logic [ADDR_W-1:0] prb_addr_r, prb_addr_nxt;
  logic [CNT_W-1:0]  top_r, top_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;

  logic              cand_ok;
  logic [DIM_W-1:0]  cand_c, cand_r;
  logic [ADDR_W-1:0] cand_addr;
  logic [DIM_W-1:0]  dim_max;
  logic              adv_last;

  logic              stk_we, stk_re;
  logic [ADDR_W-1:0] stk_addr;
  logic [ADDR_W-1:0] stk_rdata;

  bffm_ram #(
    .DEPTH (1 << ADDR_W),
    .WIDTH (ADDR_W)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .re    (stk_re),
    .addr  (stk_addr),
    .wdata (prb_addr_r),
    .rdata (stk_rdata)
  );

  // Candidate cell of the current probe: a border seed or a neighbor of the popped cell.
  always_comb begin
    cand_ok = 1'b0;
    cand_c  = '0;
    cand_r  = '0;
    if (seed_ph_r) begin
      unique case (sub_r)
        2'd0: begin
          cand_ok = seed_i_r < width;
          cand_c  = seed_i_r;
          cand_r  = '0;
        end
        2'd1: begin
          cand_ok = (seed_i_r < width) && !skip_bottom;
          cand_c  = seed_i_r;
          cand_r  = height - DIM_W'(1);
        end
        2'd2: begin
          cand_ok = seed_i_r < height;
          cand_c  = '0;
          cand_r  = seed_i_r;
        end
        default: begin
          cand_ok = seed_i_r < height;
          cand_c  = width - DIM_W'(1);
          cand_r  = seed_i_r;
        end
      endcase
    end else begin
      unique case (sub_r)
        2'd0: begin
          cand_ok = (cur_c_r + DIM_W'(1)) < width;
          cand_c  = cur_c_r + DIM_W'(1);
          cand_r  = cur_r_r;
        end
        2'd1: begin
          cand_ok = cur_c_r != '0;
          cand_c  = cur_c_r - DIM_W'(1);
          cand_r  = cur_r_r;
        end
        2'd2: begin
          cand_ok = (cur_r_r + DIM_W'(1)) < height;
          cand_c  = cur_c_r;
          cand_r  = cur_r_r + DIM_W'(1);
        end
        default: begin
          cand_ok = cur_r_r != '0;
          cand_c  = cur_c_r;
          cand_r  = cur_r_r - DIM_W'(1);
        end
      endcase
    end
    cand_addr = {cand_r[ROW_W-1:0], cand_c[COL_W-1:0]};
  end

  // The seed scan ends after the last index of the larger side; a neighbor scan after four.
  assign dim_max  = (width > height) ? width : height;
  assign adv_last = (sub_r == 2'd3) &&
                    (!seed_ph_r || ((seed_i_r + DIM_W'(1)) >= dim_max));

  // Sequencer: probe reads a cell, check marks and pushes a space, pop fetches the next cell.
  always_comb begin
    state_nxt    = state_r;
    seed_ph_nxt  = seed_ph_r;
    seed_i_nxt   = seed_i_r;
    sub_nxt      = sub_r;
    cur_c_nxt    = cur_c_r;
    cur_r_nxt    = cur_r_r;
    prb_addr_nxt = prb_addr_r;
    top_nxt      = top_r;
    cnt_nxt      = cnt_r;
    done_nxt     = 1'b0;
    cell_req     = '0;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_addr     = top_r[ADDR_W-1:0];

    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          cnt_nxt     = '0;
          top_nxt     = '0;
          seed_ph_nxt = 1'b1;
          seed_i_nxt  = '0;
          sub_nxt     = '0;
          if ((width == '0) || (height == '0)) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = F_PRB_RD;
          end
        end
      end
      F_PRB_RD: begin
        if (cand_ok) begin
          cell_req.re  = 1'b1;
          cell_req.addr = cand_addr;
          prb_addr_nxt = cand_addr;
          state_nxt    = F_PRB_CHK;
        end else begin
          sub_nxt = sub_r + 2'd1;
          if (adv_last) begin
            state_nxt = F_POP;
          end else if (sub_r == 2'd3) begin
            seed_i_nxt = seed_i_r + DIM_W'(1);
          end
        end
      end
      F_PRB_CHK: begin
        if (cell_rdata == CHAR_SPACE) begin
          cell_req.we    = 1'b1;
          cell_req.addr  = prb_addr_r;
          cell_req.wdata = CHAR_TAB;
          stk_we         = 1'b1;
          top_nxt        = top_r + CNT_W'(1);
          cnt_nxt        = cnt_r + CNT_W'(1);
        end
        sub_nxt = sub_r + 2'd1;
        if (adv_last) begin
          state_nxt = F_POP;
        end else begin
          state_nxt = F_PRB_RD;
          if (seed_ph_r && (sub_r == 2'd3)) begin
            seed_i_nxt = seed_i_r + DIM_W'(1);
          end
        end
      end
      F_POP: begin
        if (top_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = F_IDLE;
        end else begin
          stk_re    = 1'b1;
          stk_addr  = top_nxt[ADDR_W-1:0];
          top_nxt   = top_r - CNT_W'(1);
          stk_addr  = top_nxt[ADDR_W-1:0];
          state_nxt = F_POP_WAIT;
        end
      end
      F_POP_WAIT: begin
        cur_c_nxt   = DIM_W'(stk_rdata[COL_W-1:0]);
        cur_r_nxt   = DIM_W'(stk_rdata[ADDR_W-1:COL_W]);
        seed_ph_nxt = 1'b0;
        sub_nxt     = '0;
        state_nxt   = F_PRB_RD;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      top_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      done_r  <= done_nxt;
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    seed_ph_r  <= seed_ph_nxt;
    seed_i_r   <= seed_i_nxt;
    sub_r      <= sub_nxt;
    cur_c_r    <= cur_c_nxt;
    cur_r_r    <= cur_r_nxt;
    prb_addr_r <= prb_addr_nxt;
    cnt_r      <= cnt_nxt;
  end

  assign done  = done_r;
  assign count = cnt_r;

endmodule

`default_nettype wire

FILE: rtl/core/border_flood_fill_marker_top.sv
// Top level of the border flood fill marker: request handling, cell store and configuration.
// A write's result is registered in the cycle after acceptance; a read's passes the store's read
// register and T_READ. A fill scans 4*max(W,H) + 4*S candidates: in-range ones are probed in
// read and check states, others skipped, and the S marked cells popped in pop and pop-wait
// states; an empty grid ends it from idle. One request at a time; the next request is taken in
// the cycle the previous result is taken. Reset is synchronous, active low, and clears control
// and configuration; the cell store and stack hold no reset value and need no clearing.
`default_nettype none

module border_flood_fill_marker_top
  import bffm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_mode,
  input  wire logic [FIELD_W-1:0]   in_col,
  input  wire logic [FIELD_W-1:0]   in_row,
  input  wire logic [CHAR_W-1:0]    in_char_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CHAR_W-1:0]         out_char_out,
  output logic [MARK_W-1:0]         out_marked_count,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_READ = 3'b010,
    T_FILL = 3'b100
  } top_state_t;

  top_state_t        state_r, state_nxt;
  logic [CFG_W-1:0]  width_r, height_r;
  logic              skip_r;
  logic              rd_inside_r, rd_inside_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [MARK_W-1:0] out_mark_r, out_mark_nxt;

  logic              accept;
  logic              cell_in_range;
  logic              fill_start;
  logic              fill_done;
  logic [CNT_W-1:0]  fill_count;
  cell_req_t         fill_req, host_req, cell_req;
  logic [CHAR_W-1:0] cell_rdata;

  assign in_stall      = (state_r != T_IDLE) || (out_valid_r && out_stall);
  assign accept        = in_valid && !in_stall;
  assign cell_in_range = (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);

  bffm_fill u_fill (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (fill_start),
    .width       (sat_dim(width_r, MAX_WIDTH)),
    .height      (sat_dim(height_r, MAX_HEIGHT)),
    .skip_bottom (skip_r),
    .cell_rdata  (cell_rdata),
    .cell_req    (fill_req),
    .done        (fill_done),
    .count       (fill_count)
  );

  // The fill owns the cell store while it runs.
  assign cell_req = (state_r == T_FILL) ? fill_req : host_req;

  bffm_ram #(
    .DEPTH (1 << ADDR_W),
    .WIDTH (CHAR_W)
  ) u_cells (
    .clk   (clk),
    .we    (cell_req.we),
    .re    (cell_req.re),
    .addr  (cell_req.addr),
    .wdata (cell_req.wdata),
    .rdata (cell_rdata)
  );

  // Request decode and result loading.
  always_comb begin
    state_nxt     = state_r;
    rd_inside_nxt = rd_inside_r;
    host_req      = '0;
    host_req.addr = cell_addr(in_col, in_row);
    host_req.wdata = in_char_in;
    fill_start    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_mark_nxt  = out_mark_r;

    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_mode))
            MODE_WRITE: begin
              host_req.we   = cell_in_range;
              out_valid_nxt = 1'b1;
              out_char_nxt  = '0;
              out_mark_nxt  = '0;
            end
            MODE_FILL: begin
              fill_start = 1'b1;
              state_nxt  = T_FILL;
            end
            MODE_READ: begin
              host_req.re   = 1'b1;
              rd_inside_nxt = cell_in_range;
              state_nxt     = T_READ;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = '0;
              out_mark_nxt  = '0;
            end
          endcase
        end
      end
      T_READ: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rd_inside_r ? cell_rdata : '0;
        out_mark_nxt  = '0;
        state_nxt     = T_IDLE;
      end
      T_FILL: begin
        if (fill_done) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_mark_nxt  = MARK_W'(fill_count);
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      width_r     <= CFG_W'(1);
      height_r    <= CFG_W'(1);
      skip_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SPRITE_WIDTH:  width_r  <= cfg_wdata;
          CFG_SPRITE_HEIGHT: height_r <= cfg_wdata;
          CFG_SKIP_BOTTOM:   skip_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    rd_inside_r <= rd_inside_nxt;
    out_char_r  <= out_char_nxt;
    out_mark_r  <= out_mark_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_char_out     = out_char_r;
  assign out_marked_count = out_mark_r;

endmodule

`default_nettype wire
